// ===== rtl/hrhp_pkg.sv =====
package hrhp_pkg;

  localparam int LINE_BUFFER_BYTES = 2048;
  localparam int LINE_LIMIT_INT    = LINE_BUFFER_BYTES - 4;
  localparam int LINE_LEN_W        = $clog2(LINE_LIMIT_INT + 1);
  localparam logic [LINE_LEN_W-1:0] LINE_LIMIT = LINE_LEN_W'(LINE_LIMIT_INT);

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [9:0] CODE_MAX = 10'd999;

  localparam logic [2:0] PH_STATUS = 3'd0;
  localparam logic [2:0] PH_NAME   = 3'd1;
  localparam logic [2:0] PH_SKIP   = 3'd2;
  localparam logic [2:0] PH_VALUE  = 3'd3;
  localparam logic [2:0] PH_BODY   = 3'd4;

  localparam logic [1:0] SCAN_BEFORE_SPACE = 2'd0;
  localparam logic [1:0] SCAN_LEADING_WS   = 2'd1;
  localparam logic [1:0] SCAN_DIGITS       = 2'd2;
  localparam logic [1:0] SCAN_DONE         = 2'd3;

  localparam logic [2:0] K_STATUS   = 3'd0;
  localparam logic [2:0] K_NAME     = 3'd1;
  localparam logic [2:0] K_VALUE    = 3'd2;
  localparam logic [2:0] K_HDR_DONE = 3'd3;
  localparam logic [2:0] K_HEAD_END = 3'd4;
  localparam logic [2:0] K_BODY     = 3'd5;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [2:0]            phase;
    logic                  cr_pending;
    logic [1:0]            code_scan;
    logic [9:0]            code_value;
    logic [LINE_LEN_W-1:0] line_length;
    logic                  overflow_seen;
  } state_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_out;
    logic [9:0] status_code;
    logic       format_error;
    logic       line_overflow;
    logic       last;
  } result_t;

  typedef struct packed {
    state_t  st;
    logic    emit;
    result_t res;
  } step_t;

  localparam state_t STATE_RESET = '{
    phase:         PH_STATUS,
    cr_pending:    1'b0,
    code_scan:     SCAN_BEFORE_SPACE,
    code_value:    10'd0,
    line_length:   '0,
    overflow_seen: 1'b0
  };

endpackage

// ===== rtl/http_response_head_parser_unit.sv =====
// result words are written into the queue registers and offered from its head
// throughput: one byte per cycle while the queue has room; a byte that yields two result
//   words (stray cr followed by a content byte) queues both for the single output port
// results wait in a four-entry queue; input is taken while at least two entries are free
// reset (rst, synchronous, active high) returns the parser to the status line and
//   empties the result queue
module http_response_head_parser_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic        s_axis_tuser,   // op
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // data_out, status_code, format_error, line_overflow, pad
  output logic [2:0]  m_axis_tuser,   // kind
  output logic        m_axis_tlast    // last
);

  hrhp_pkg::state_t  st;
  hrhp_pkg::state_t  st_next;
  hrhp_pkg::result_t q [hrhp_pkg::QDEPTH];
  logic [hrhp_pkg::QPTR_W-1:0] wr_ptr;
  logic [hrhp_pkg::QPTR_W-1:0] rd_ptr;
  logic [hrhp_pkg::QCNT_W-1:0] count;
  logic [hrhp_pkg::QCNT_W-1:0] count_next;

  logic              in_acc;
  logic              out_acc;
  hrhp_pkg::step_t   ea;
  hrhp_pkg::step_t   eb;
  hrhp_pkg::result_t slot0;
  hrhp_pkg::result_t slot1;
  logic [1:0]        n_res;
  hrhp_pkg::result_t head;

  function automatic logic is_ws(logic [7:0] b);
    return (b == hrhp_pkg::CHAR_SPACE) || (b >= hrhp_pkg::CHAR_TAB && b <= hrhp_pkg::CHAR_CR);
  endfunction

  // one content byte of a line
  function automatic hrhp_pkg::step_t feed(hrhp_pkg::state_t s, logic [7:0] b);
    hrhp_pkg::step_t f;
    logic [13:0]     v;
    f.st   = s;
    f.emit = 1'b0;
    f.res  = '0;
    v = 14'(s.code_value) * 14'd10 + 14'(b[3:0]);
    if (s.line_length >= hrhp_pkg::LINE_LIMIT) begin
      f.st.overflow_seen = 1'b1;
    end else begin
      f.st.line_length = s.line_length + 1'b1;
      unique case (s.phase)
        hrhp_pkg::PH_STATUS: begin
          if (s.code_scan == hrhp_pkg::SCAN_BEFORE_SPACE) begin
            if (b == hrhp_pkg::CHAR_SPACE) f.st.code_scan = hrhp_pkg::SCAN_LEADING_WS;
          end else if (s.code_scan != hrhp_pkg::SCAN_DONE) begin
            if (s.code_scan == hrhp_pkg::SCAN_LEADING_WS && is_ws(b)) begin
              f.st.code_scan = s.code_scan;
            end else if (b >= hrhp_pkg::CHAR_ZERO && b <= hrhp_pkg::CHAR_NINE) begin
              f.st.code_value = (v > 14'(hrhp_pkg::CODE_MAX)) ? hrhp_pkg::CODE_MAX : v[9:0];
              f.st.code_scan  = hrhp_pkg::SCAN_DIGITS;
            end else begin
              f.st.code_scan = hrhp_pkg::SCAN_DONE;
            end
          end
        end
        hrhp_pkg::PH_NAME: begin
          if (b == hrhp_pkg::CHAR_COLON) begin
            f.st.phase = hrhp_pkg::PH_SKIP;
          end else begin
            f.emit         = 1'b1;
            f.res.kind     = hrhp_pkg::K_NAME;
            f.res.data_out = b;
          end
        end
        hrhp_pkg::PH_SKIP: begin
          f.st.phase = hrhp_pkg::PH_VALUE;
        end
        hrhp_pkg::PH_VALUE: begin
          f.emit         = 1'b1;
          f.res.kind     = hrhp_pkg::K_VALUE;
          f.res.data_out = b;
        end
        default: begin
          f.st.phase = s.phase;
        end
      endcase
    end
    return f;
  endfunction

  function automatic hrhp_pkg::step_t end_line(hrhp_pkg::state_t s);
    hrhp_pkg::step_t f;
    f.st   = s;
    f.emit = 1'b1;
    f.res  = '0;
    if (s.phase == hrhp_pkg::PH_STATUS) begin
      f.res.kind          = hrhp_pkg::K_STATUS;
      f.res.status_code   = s.code_value;
      f.res.format_error  = (s.code_scan == hrhp_pkg::SCAN_BEFORE_SPACE);
      f.res.line_overflow = s.overflow_seen;
      f.st.phase          = hrhp_pkg::PH_NAME;
    end else if (s.line_length == '0 && !s.overflow_seen) begin
      f.res.kind = hrhp_pkg::K_HEAD_END;
      f.st.phase = hrhp_pkg::PH_BODY;
    end else begin
      f.res.kind          = hrhp_pkg::K_HDR_DONE;
      f.res.format_error  = (s.phase == hrhp_pkg::PH_NAME);
      f.res.line_overflow = s.overflow_seen;
      f.st.phase          = hrhp_pkg::PH_NAME;
    end
    f.st.line_length   = '0;
    f.st.overflow_seen = 1'b0;
    f.st.cr_pending    = 1'b0;
    return f;
  endfunction

  assign s_axis_tready = (count <= hrhp_pkg::QCNT_W'(hrhp_pkg::QDEPTH - 2));
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign m_axis_tvalid = (count != '0);
  assign out_acc       = m_axis_tvalid && m_axis_tready;

  always_comb begin
    ea       = '0;
    eb       = '0;
    ea.st    = st;
    eb.st    = st;
    st_next  = st;
    if (in_acc) begin
      if (s_axis_tuser) begin
        st_next = hrhp_pkg::STATE_RESET;
      end else if (st.phase >= hrhp_pkg::PH_BODY) begin
        st_next.phase   = hrhp_pkg::PH_BODY;
        ea.emit         = 1'b1;
        ea.res.kind     = hrhp_pkg::K_BODY;
        ea.res.data_out = s_axis_tdata;
      end else if (st.cr_pending) begin
        if (s_axis_tdata == hrhp_pkg::CHAR_LF) begin
          ea      = end_line(st);
          st_next = ea.st;
        end else begin
          ea = feed(st, hrhp_pkg::CHAR_CR);
          if (s_axis_tdata == hrhp_pkg::CHAR_CR) begin
            st_next            = ea.st;
            st_next.cr_pending = 1'b1;
          end else begin
            eb.st            = ea.st;
            eb.st.cr_pending = 1'b0;
            eb               = feed(eb.st, s_axis_tdata);
            st_next          = eb.st;
          end
        end
      end else if (s_axis_tdata == hrhp_pkg::CHAR_CR) begin
        st_next.cr_pending = 1'b1;
      end else begin
        ea      = feed(st, s_axis_tdata);
        st_next = ea.st;
      end
    end
  end

  always_comb begin
    slot0 = ea.emit ? ea.res : eb.res;
    slot1 = eb.res;
    n_res = {1'b0, ea.emit} + {1'b0, eb.emit};
    slot0.last = (n_res == 2'd1);
    slot1.last = 1'b1;
  end

  assign count_next = count + hrhp_pkg::QCNT_W'(n_res) - hrhp_pkg::QCNT_W'(out_acc);

  always_ff @(posedge clk) begin
    if (rst) begin
      st     <= hrhp_pkg::STATE_RESET;
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      st     <= st_next;
      wr_ptr <= wr_ptr + hrhp_pkg::QPTR_W'(n_res);
      rd_ptr <= rd_ptr + hrhp_pkg::QPTR_W'(out_acc);
      count  <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (n_res != 2'd0) q[wr_ptr] <= slot0;
    if (n_res == 2'd2) q[wr_ptr + 1'b1] <= slot1;
  end

  assign head         = q[rd_ptr];
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;
  assign m_axis_tdata = {4'd0, head.line_overflow, head.format_error, head.status_code,
                         head.data_out};

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= hrhp_pkg::QCNT_W'(hrhp_pkg::QDEPTH))
    else $error("result queue over capacity");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_acc && s_axis_tuser |=> st.phase == hrhp_pkg::PH_STATUS && !st.cr_pending
                               && st.line_length == '0 && count == $past(count_next))
    else $error("restart did not return parser to status line");

  a_body_no_cr: assert property (@(posedge clk) disable iff (rst)
    st.phase >= hrhp_pkg::PH_BODY |-> !st.cr_pending)
    else $error("cr held back in body");

  a_line_len: assert property (@(posedge clk) disable iff (rst)
    st.line_length <= hrhp_pkg::LINE_LIMIT)
    else $error("line length past limit");

endmodule

// ===== tb/sv/http_response_head_parser_unit_tb.sv =====
module http_response_head_parser_unit_tb;
  import hrhp_pkg::*;

  localparam logic OP_BYTE    = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [7:0] CHAR_VT    = 8'h0B;
  localparam logic [7:0] CHAR_FF    = 8'h0C;
  localparam logic [7:0] CHAR_BANG  = 8'h21;
  localparam logic [7:0] CHAR_TILDE = 8'h7E;

  localparam int USE_MODEL    = -1;
  localparam int ITEMS_TARGET = 1750;
  localparam int HOLD_CYCLES  = 400;
  localparam int DRAIN_CYCLES = 10;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int N_ROWS       = 24;

  localparam result_t NO_WORD = '0;

  typedef enum logic [1:0] {RX_STALLS, TX_GAPS, NO_IDLE} idle_mode_t;

  typedef struct {
    logic       op;
    logic [7:0] b;
    int         typed_n;
    result_t    typed;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // data_byte
  logic        s_axis_tuser = 1'b0;    // op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;           // data_out, status_code, format_error, line_overflow, pad
  logic [2:0]  m_axis_tuser;           // kind
  logic        m_axis_tlast;

  // parser copy
  logic [2:0]  ph;
  logic        cr_held;
  logic [1:0]  scan;
  logic [9:0]  code;
  int          line_len;
  logic        ovf;
  result_t     step_res [2];
  int          step_n;

  result_t     expected_words [$];
  result_t     head_word;
  dir_row_t    dir_rows [N_ROWS];
  logic [7:0]  ws_set [6];
  idle_mode_t  idle_mode = RX_STALLS;
  int          items_sent = 0;
  int          long_bytes = 0;
  int          error_count = 0;
  int          cycle_count = 0;
  int          hold_left = 0;
  logic        hold_done = 1'b0;
  int          resp_idx;

  http_response_head_parser_unit uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #5 clk = ~clk;

  function automatic result_t word(logic [2:0] k, logic [7:0] d, logic [9:0] c, logic e,
                                   logic o);
    return '{kind: k, data_out: d, status_code: c, format_error: e, line_overflow: o,
             last: 1'b1};
  endfunction

  function void restart_parser();
    ph       = PH_STATUS;
    cr_held  = 1'b0;
    scan     = SCAN_BEFORE_SPACE;
    code     = '0;
    line_len = 0;
    ovf      = 1'b0;
  endfunction

  function void add_word(logic [2:0] k, logic [7:0] d, logic [9:0] c, logic e, logic o);
    if (step_n < 2) begin
      step_res[step_n] = word(k, d, c, e, o);
      step_res[step_n].last = 1'b0;
      step_n++;
    end
  endfunction

  function void take_content(logic [7:0] b);
    int v;
    if (line_len >= LINE_LIMIT_INT) begin
      ovf = 1'b1;
      return;
    end
    line_len++;
    case (ph)
      PH_STATUS: begin
        if (scan == SCAN_BEFORE_SPACE) begin
          if (b == CHAR_SPACE) scan = SCAN_LEADING_WS;
        end else if (scan != SCAN_DONE) begin
          if (!(scan == SCAN_LEADING_WS &&
                (b == CHAR_SPACE || (b >= CHAR_TAB && b <= CHAR_CR)))) begin
            if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
              v = int'(code) * 10 + int'(b - CHAR_ZERO);
              code = (v > int'(CODE_MAX)) ? CODE_MAX : 10'(v);
              scan = SCAN_DIGITS;
            end else begin
              scan = SCAN_DONE;
            end
          end
        end
      end
      PH_NAME: begin
        if (b == CHAR_COLON) ph = PH_SKIP;
        else add_word(K_NAME, b, '0, 1'b0, 1'b0);
      end
      PH_SKIP: ph = PH_VALUE;
      PH_VALUE: add_word(K_VALUE, b, '0, 1'b0, 1'b0);
      default: ;
    endcase
  endfunction

  function void close_line();
    if (ph == PH_STATUS) begin
      add_word(K_STATUS, '0, code, scan == SCAN_BEFORE_SPACE, ovf);
      ph = PH_NAME;
    end else if (line_len == 0 && !ovf) begin
      add_word(K_HEAD_END, '0, '0, 1'b0, 1'b0);
      ph = PH_BODY;
    end else begin
      add_word(K_HDR_DONE, '0, '0, ph == PH_NAME, ovf);
      ph = PH_NAME;
    end
    line_len = 0;
    ovf      = 1'b0;
    cr_held  = 1'b0;
  endfunction

  function void parse_byte(logic op, logic [7:0] b);
    step_n = 0;
    if (op == OP_RESTART) begin
      restart_parser();
      return;
    end
    if (ph >= PH_BODY) begin
      ph = PH_BODY;
      add_word(K_BODY, b, '0, 1'b0, 1'b0);
    end else if (cr_held) begin
      if (b == CHAR_LF) begin
        close_line();
      end else begin
        take_content(CHAR_CR);
        if (b == CHAR_CR) begin
          cr_held = 1'b1;
        end else begin
          cr_held = 1'b0;
          take_content(b);
        end
      end
    end else if (b == CHAR_CR) begin
      cr_held = 1'b1;
    end else begin
      take_content(b);
    end
    if (step_n > 0) step_res[step_n-1].last = 1'b1;
  endfunction

  function automatic logic [7:0] rand_text();
    logic [7:0] c;
    if ($urandom_range(0, 15) == 0) return 8'($urandom);
    c = 8'($urandom_range(CHAR_BANG, CHAR_TILDE));
    return (c == CHAR_COLON) ? "_" : c;
  endfunction

  function automatic logic sender_idles();
    case (idle_mode)
      RX_STALLS: return $urandom_range(0, 99) < 7;
      TX_GAPS:   return $urandom_range(0, 99) < 60;
      default:   return 1'b0;
    endcase
  endfunction

  task automatic offer_byte(input logic op, input logic [7:0] b, input int typed_n,
                            input result_t typed);
    int k;
    int short_items;
    while (sender_idles()) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= b;
    do @(posedge clk); while (!s_axis_tready);
    parse_byte(op, b);
    if (typed_n == USE_MODEL) begin
      for (k = 0; k < step_n; k++) expected_words.push_back(step_res[k]);
    end else begin
      for (k = 0; k < typed_n; k++) expected_words.push_back(typed);
    end
    items_sent++;
    short_items = items_sent - long_bytes;
    idle_mode <= (short_items < 600) ? RX_STALLS : (short_items < 1200) ? TX_GAPS : NO_IDLE;
  endtask

  task automatic send_byte(input logic [7:0] b);
    offer_byte(OP_BYTE, b, USE_MODEL, NO_WORD);
  endtask

  task automatic send_filler(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      long_bytes++;
      send_byte(8'($urandom_range(CHAR_BANG, CHAR_TILDE)));
    end
  endtask

  task automatic send_response(input int idx);
    int k;
    int h;
    int len;
    int n_hdr;
    offer_byte(OP_RESTART, 8'($urandom), USE_MODEL, NO_WORD);
    // status line
    len = $urandom_range(1, 8);
    for (k = 0; k < len; k++) send_byte(rand_text());
    if ($urandom_range(0, 9) != 0) begin
      send_byte(CHAR_SPACE);
      len = $urandom_range(0, 2);
      for (k = 0; k < len; k++) send_byte(ws_set[$urandom_range(0, 5)]);
      len = $urandom_range(0, 4);
      for (k = 0; k < len; k++) send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
      if ($urandom_range(0, 1) != 0) begin
        send_byte(CHAR_SPACE);
        len = $urandom_range(0, 6);
        for (k = 0; k < len; k++) send_byte(rand_text());
      end
    end
    if (idx == 2) send_filler($urandom_range(2040, 2070));
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    // header lines
    n_hdr = $urandom_range(1, 4);
    for (h = 0; h < n_hdr; h++) begin
      len = $urandom_range(0, 6);
      for (k = 0; k < len; k++) send_byte(rand_text());
      if (idx == 7 && h == 0) send_filler($urandom_range(2040, 2070));
      if ($urandom_range(0, 7) != 0) begin
        send_byte(CHAR_COLON);
        if ($urandom_range(0, 3) != 0) send_byte(CHAR_SPACE);
        len = $urandom_range(0, 8);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0) send_byte(CHAR_CR);
          send_byte(rand_text());
        end
        if (idx == 4 && h == 0) send_filler($urandom_range(2040, 2070));
      end
      send_byte(CHAR_CR);
      send_byte(CHAR_LF);
    end
    if ($urandom_range(0, 11) == 0) return;
    send_byte(CHAR_CR);
    send_byte(CHAR_LF);
    len = $urandom_range(0, 16);
    for (k = 0; k < len; k++) send_byte(8'($urandom));
  endtask

  function void check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endfunction

  // receiver side with one long hold-off when idling stops
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (idle_mode == NO_IDLE && !hold_done) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      m_axis_tready <= 1'b0;
    end else begin
      case (idle_mode)
        RX_STALLS: m_axis_tready <= $urandom_range(0, 99) >= 60;
        TX_GAPS:   m_axis_tready <= $urandom_range(0, 99) >= 7;
        default:   m_axis_tready <= 1'b1;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: kind %0d, tdata %h", m_axis_tuser, m_axis_tdata);
        error_count++;
      end else begin
        head_word = expected_words.pop_front();
        check_field("kind", head_word.kind, m_axis_tuser);
        check_field("data_out", head_word.data_out, m_axis_tdata[7:0]);
        check_field("status_code", head_word.status_code, m_axis_tdata[17:8]);
        check_field("format_error", head_word.format_error, m_axis_tdata[18]);
        check_field("line_overflow", head_word.line_overflow, m_axis_tdata[19]);
        check_field("last", head_word.last, m_axis_tlast);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("http_response_head_parser_unit_tb: done, errors");
      $finish;
    end
  end

  initial begin
    ws_set = '{CHAR_SPACE, CHAR_TAB, CHAR_LF, CHAR_VT, CHAR_FF, CHAR_CR};
    dir_rows = '{
      '{OP_RESTART, 8'h00,      0,         NO_WORD},
      '{OP_BYTE,    CHAR_SPACE, 0,         NO_WORD},
      '{OP_BYTE,    "9",        0,         NO_WORD},
      '{OP_BYTE,    "9",        0,         NO_WORD},
      '{OP_BYTE,    "9",        0,         NO_WORD},
      '{OP_BYTE,    "9",        0,         NO_WORD},
      '{OP_BYTE,    CHAR_CR,    0,         NO_WORD},
      '{OP_BYTE,    CHAR_LF,    1,         word(K_STATUS, 8'h00, CODE_MAX, 1'b0, 1'b0)},
      '{OP_BYTE,    CHAR_COLON, 0,         NO_WORD},
      '{OP_BYTE,    CHAR_CR,    0,         NO_WORD},
      '{OP_BYTE,    CHAR_LF,    1,         word(K_HDR_DONE, 8'h00, 10'd0, 1'b0, 1'b0)},
      '{OP_BYTE,    8'hFF,      1,         word(K_NAME, 8'hFF, 10'd0, 1'b0, 1'b0)},
      '{OP_BYTE,    CHAR_CR,    0,         NO_WORD},
      '{OP_BYTE,    "z",        USE_MODEL, NO_WORD},
      '{OP_BYTE,    CHAR_CR,    0,         NO_WORD},
      '{OP_BYTE,    CHAR_LF,    1,         word(K_HDR_DONE, 8'h00, 10'd0, 1'b1, 1'b0)},
      '{OP_BYTE,    CHAR_CR,    0,         NO_WORD},
      '{OP_BYTE,    CHAR_LF,    1,         word(K_HEAD_END, 8'h00, 10'd0, 1'b0, 1'b0)},
      '{OP_BYTE,    8'h00,      1,         word(K_BODY, 8'h00, 10'd0, 1'b0, 1'b0)},
      '{OP_BYTE,    CHAR_CR,    1,         word(K_BODY, CHAR_CR, 10'd0, 1'b0, 1'b0)},
      '{OP_RESTART, 8'hFF,      0,         NO_WORD},
      '{OP_BYTE,    "A",        0,         NO_WORD},
      '{OP_BYTE,    CHAR_CR,    0,         NO_WORD},
      '{OP_BYTE,    CHAR_LF,    1,         word(K_STATUS, 8'h00, 10'd0, 1'b1, 1'b0)}
    };
    restart_parser();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    foreach (dir_rows[i])
      offer_byte(dir_rows[i].op, dir_rows[i].b, dir_rows[i].typed_n, dir_rows[i].typed);
    resp_idx = 0;
    while (items_sent - long_bytes < ITEMS_TARGET + N_ROWS) begin
      send_response(resp_idx);
      resp_idx++;
    end
    s_axis_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("http_response_head_parser_unit_tb: done, clean");
    end else begin
      $display("http_response_head_parser_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/hrhp_pkg.sv
rtl/http_response_head_parser_unit.sv
tb/sv/http_response_head_parser_unit_tb.sv
